@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that cons holds in the cycle after ante, outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

// Checks that cons holds in the cycle after ante, also through reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/mrsh_pkg.sv @@
// Package of the stream hash: types, constants, program table and helper functions.
package mrsh_pkg;

  localparam int IN_DEPTH_DEF = 2;
  localparam int OUT_DEPTH = 4;

  localparam logic [63:0] MUL_P = 64'hFFFF_FFFF_FFFF_FFC5;
  localparam logic [63:0] MUL_Q = 64'd13166748625691186689;
  localparam logic [63:0] MUL_R = 64'd1573836600196043749;
  localparam logic [63:0] MUL_S = 64'd1478582680485693857;
  localparam logic [63:0] MUL_T = 64'd1584163446043636637;
  localparam logic [63:0] MUL_U = 64'd1358537349836140151;
  localparam logic [63:0] MUL_V = 64'd2849285319520710901;
  localparam logic [63:0] MUL_W = 64'd2366157163652459183;

  localparam logic [1:0] REG_SEED = 2'd0;
  localparam logic [1:0] REG_LENGTH = 2'd1;
  localparam logic [1:0] REG_OUT_SIZE = 2'd2;
  localparam logic [1:0] REG_BYTE_ORDER = 2'd3;

  localparam logic [1:0] SIZE_64 = 2'd0;
  localparam logic [1:0] SIZE_128 = 2'd1;

  localparam logic [2:0] OP_ABSORB = 3'd0;
  localparam logic [2:0] OP_MIX_A = 3'd1;
  localparam logic [2:0] OP_MIX_B = 3'd2;
  localparam logic [2:0] OP_ROT = 3'd3;
  localparam logic [2:0] OP_TAIL = 3'd4;
  localparam logic [2:0] OP_EMIT = 3'd5;
  localparam logic [2:0] OP_DONE = 3'd6;

  localparam logic [4:0] PC_CHUNK_A = 5'd0;
  localparam logic [4:0] PC_CHUNK_B = 5'd3;
  localparam logic [4:0] PC_LAST = 5'd7;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [3:0]  tail;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [63:0] hash;
    logic [1:0]  idx;
    logic        fin;
  } res_t;

  function automatic logic [2:0] prog_op(input logic [4:0] pc);
    case (pc)
      5'd0: prog_op = OP_ABSORB;
      5'd1: prog_op = OP_MIX_A;
      5'd2: prog_op = OP_DONE;
      5'd3: prog_op = OP_ABSORB;
      5'd4: prog_op = OP_MIX_B;
      5'd5: prog_op = OP_ROT;
      5'd6: prog_op = OP_DONE;
      5'd7: prog_op = OP_MIX_B;
      5'd8: prog_op = OP_TAIL;
      5'd9: prog_op = OP_MIX_A;
      5'd10: prog_op = OP_MIX_B;
      5'd11: prog_op = OP_MIX_A;
      5'd12: prog_op = OP_EMIT;
      5'd13: prog_op = OP_MIX_A;
      5'd14: prog_op = OP_EMIT;
      5'd15: prog_op = OP_MIX_A;
      5'd16: prog_op = OP_MIX_B;
      5'd17: prog_op = OP_MIX_A;
      5'd18: prog_op = OP_EMIT;
      5'd19: prog_op = OP_MIX_A;
      5'd20: prog_op = OP_EMIT;
      default: prog_op = OP_DONE;
    endcase
  endfunction

  function automatic logic [63:0] swap_bytes(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = x[8*(7-i) +: 8];
    end
    return r;
  endfunction

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

endpackage

@@ sv/multiply_rotate_stream_hash.sv @@
// Top level of the multiply-rotate stream hash: configuration registers and the two halves.
//
// Usage. Write seed, msg_length, out_size and byte_order through the cfg port
// while the block is idle. Then push the message as one transaction per
// 16-byte chunk with in_is_last low, followed by one transaction with
// in_is_last high that carries the 0 to 15 tail bytes and in_tail_count.
// Chunk transactions give no result; the last one gives one, two or four
// digest words on the result queue, each tagged with its index, the final one
// with out_final_word high.
// A chunk passes through the mixing sequencer as mix A, or as mix B and word
// rotation; each mix is four dependent multiply steps, each of which is issued
// to its lane multiplier and then takes the registered product. The last item
// runs mix B, the tail addition and further mixes before each digest word.
// An input queue decouples the input side from the sequencer, so new items
// are taken while the sequencer works, until that queue is full.
// Reset clears both queues and starts a new message; registers read zero.
// When the receiver stalls, up to four digest words wait in the result queue;
// beyond that the sequencer holds, and the input queue fills and raises full.
module multiply_rotate_stream_hash #(
  parameter int IN_DEPTH = mrsh_pkg::IN_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [63:0] in_bytes_low,
  input  logic [63:0] in_bytes_high,
  input  logic [3:0]  in_tail_count,
  input  logic        in_is_last,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_hash_word,
  output logic [1:0]  out_word_index,
  output logic        out_final_word,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  import mrsh_pkg::*;

  logic [63:0] seed_r;
  logic [31:0] length_r;
  logic [1:0]  size_r;
  logic        order_r;
  item_t       head;
  logic        head_valid, head_pop;

  // Configuration registers; a write with cfg_we high updates the register that cfg_index selects.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      length_r <= '0;
      size_r <= '0;
      order_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEED: seed_r <= cfg_wdata;
        REG_LENGTH: length_r <= cfg_wdata[31:0];
        REG_OUT_SIZE: size_r <= cfg_wdata[1:0];
        REG_BYTE_ORDER: order_r <= cfg_wdata[0];
        default: order_r <= order_r;
      endcase
    end
  end

  mrsh_front #(.IN_DEPTH(IN_DEPTH)) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_bytes_low(in_bytes_low),
    .in_bytes_high(in_bytes_high),
    .in_tail_count(in_tail_count),
    .in_is_last(in_is_last),
    .byte_order(order_r),
    .head(head),
    .head_valid(head_valid),
    .head_pop(head_pop)
  );

  mrsh_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .head(head),
    .head_valid(head_valid),
    .head_pop(head_pop),
    .seed(seed_r),
    .msg_length(length_r),
    .out_size(size_r),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_hash_word(out_hash_word),
    .out_word_index(out_word_index),
    .out_final_word(out_final_word)
  );
endmodule

@@ sv/mrsh_front.sv @@
// Front end: input queue that takes items and puts chunk words into byte order.
module mrsh_front #(
  parameter int IN_DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  logic [63:0]     in_bytes_low,
  input  logic [63:0]     in_bytes_high,
  input  logic [3:0]      in_tail_count,
  input  logic            in_is_last,
  input  logic            byte_order,
  output mrsh_pkg::item_t head,
  output logic            head_valid,
  input  logic            head_pop
);
  import mrsh_pkg::*;

  localparam int PW = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
  localparam int CW = $clog2(IN_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(IN_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(IN_DEPTH);

  item_t          q_r [IN_DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  item_t          in_item;
  logic           do_push, do_pop;

  always_comb begin
    in_item.lo = (byte_order && !in_is_last) ? swap_bytes(in_bytes_low) : in_bytes_low;
    in_item.hi = (byte_order && !in_is_last) ? swap_bytes(in_bytes_high) : in_bytes_high;
    in_item.tail = in_tail_count;
    in_item.last = in_is_last;
  end

  assign in_full = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head = q_r[rp_r];
  assign do_push = in_push && !in_full;
  assign do_pop = head_pop && head_valid;

  always_comb begin
    wp_nxt = do_push ? ((wp_r == LAST_PTR) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt = do_pop ? ((rp_r == LAST_PTR) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= in_item;
    end
  end
endmodule

@@ sv/mrsh_back.sv @@
// Back end: mixing sequencer with two multiply lanes and the result queue.
module mrsh_back (
  input  logic            clk,
  input  logic            rst_n,
  input  mrsh_pkg::item_t head,
  input  logic            head_valid,
  output logic            head_pop,
  input  logic [63:0]     seed,
  input  logic [31:0]     msg_length,
  input  logic [1:0]      out_size,
  output logic            out_empty,
  input  logic            out_pop,
  output logic [63:0]     out_hash_word,
  output logic [1:0]      out_word_index,
  output logic            out_final_word
);
  import mrsh_pkg::*;

  logic [63:0] s_r [4];
  logic [63:0] s_nxt [4];
  logic [63:0] t_r [2];
  logic [63:0] t_nxt [2];
  logic [63:0] ll_r [2];
  logic [63:0] ll_nxt [2];
  logic [31:0] cr_r [2];
  logic [31:0] cr_nxt [2];
  logic [63:0] prod [2];
  logic [63:0] opnd [2];
  logic [63:0] kon [2];
  item_t       it_r;
  logic        busy_r, busy_nxt, fresh_r, fresh_nxt, odd_r, odd_nxt;
  logic [4:0]  pc_r, pc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [1:0]  eidx_r, eidx_nxt;
  logic [2:0]  op;
  logic [1:0]  step;
  logic [63:0] base;
  logic [63:0] tadd [15];
  logic [63:0] tsum [4];
  logic [1:0]  last_idx;
  logic        start;

  res_t        oq_r [OUT_DEPTH];
  logic [1:0]  owp_r, orp_r;
  logic [2:0]  ocnt_r;
  logic        opush, opop, ofull;
  res_t        ores;

  assign op = prog_op(pc_r);
  assign step = cnt_r[2:1];
  assign base = seed + {32'd0, msg_length};
  assign start = !busy_r && head_valid;
  assign head_pop = start;
  assign last_idx = (out_size == SIZE_64) ? 2'd0 : ((out_size == SIZE_128) ? 2'd1 : 2'd3);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      prod[l] = ll_r[l] + {cr_r[l], 32'd0};
    end
  end

  // Operand and constant of each lane for the issue half of a mix step.
  always_comb begin
    opnd[0] = s_r[0];
    kon[0] = MUL_P;
    opnd[1] = s_r[2];
    kon[1] = MUL_T;
    if (op == OP_MIX_B) begin
      case (step)
        2'd0: begin opnd[0] = s_r[1]; kon[0] = MUL_V; end
        2'd1: begin opnd[0] = rotr(t_r[0], 23); kon[0] = MUL_W; end
        2'd2: begin opnd[0] = s_r[2] ^ (t_r[0] + seed); kon[0] = MUL_R; end
        default: begin opnd[0] = rotr(t_r[0], 23); kon[0] = MUL_S; end
      endcase
    end else begin
      case (step)
        2'd0: begin
          opnd[0] = s_r[0]; kon[0] = MUL_P; opnd[1] = s_r[2]; kon[1] = MUL_T;
        end
        2'd1: begin
          opnd[0] = rotr(t_r[0], 23); kon[0] = MUL_Q;
          opnd[1] = rotr(t_r[1], 31); kon[1] = MUL_U;
        end
        2'd2: begin
          opnd[0] = s_r[1] ^ s_r[0]; kon[0] = MUL_R;
          opnd[1] = s_r[3] ^ s_r[2]; kon[1] = MUL_V;
        end
        default: begin
          opnd[0] = rotr(t_r[0], 29); kon[0] = MUL_S;
          opnd[1] = rotr(t_r[1], 37); kon[1] = MUL_W;
        end
      endcase
    end
    for (int l = 0; l < 2; l++) begin
      ll_nxt[l] = {32'd0, opnd[l][31:0]} * {32'd0, kon[l][31:0]};
      cr_nxt[l] = 32'(opnd[l][63:32] * kon[l][31:0]) + 32'(opnd[l][31:0] * kon[l][63:32]);
    end
  end

  // Tail bytes land at fixed word positions and shifts.
  always_comb begin
    for (int k = 0; k < 15; k++) begin
      logic [7:0] b;
      int sh;
      b = (k < 8) ? it_r.lo[8*k +: 8] : it_r.hi[8*(k-8) +: 8];
      sh = (k < 7) ? 8 * k : ((k == 7) ? 0 : 8 * (k - 7));
      tadd[k] = (4'(k) < it_r.tail) ? ({56'd0, b} << sh) : 64'd0;
    end
    tsum[0] = s_r[0] + tadd[2] + tadd[6] + tadd[10] + tadd[14];
    tsum[1] = s_r[1] + tadd[1] + tadd[5] + tadd[9] + tadd[13];
    tsum[2] = s_r[2] + tadd[0] + tadd[4] + tadd[8] + tadd[12];
    tsum[3] = s_r[3] + tadd[3] + tadd[7] + tadd[11];
  end

  always_comb begin
    for (int w = 0; w < 4; w++) begin
      s_nxt[w] = s_r[w];
    end
    for (int l = 0; l < 2; l++) begin
      t_nxt[l] = t_r[l];
    end
    busy_nxt = busy_r;
    fresh_nxt = fresh_r;
    odd_nxt = odd_r;
    pc_nxt = pc_r;
    cnt_nxt = cnt_r;
    eidx_nxt = eidx_r;
    opush = 1'b0;
    ores.hash = 64'd0 - s_r[2] - s_r[3];
    ores.idx = eidx_r;
    ores.fin = (eidx_r == last_idx);
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
      eidx_nxt = '0;
      if (fresh_r) begin
        s_nxt[0] = base + 64'd1;
        s_nxt[1] = base + 64'd2;
        s_nxt[2] = base + 64'd3;
        s_nxt[3] = base + 64'd5;
        odd_nxt = 1'b0;
        fresh_nxt = 1'b0;
      end
      if (head.last) begin
        pc_nxt = PC_LAST;
      end else if (odd_r && !fresh_r) begin
        pc_nxt = PC_CHUNK_B;
      end else begin
        pc_nxt = PC_CHUNK_A;
      end
    end else if (busy_r) begin
      case (op)
        OP_ABSORB: begin
          s_nxt[0] = s_r[0] - it_r.lo;
          s_nxt[1] = s_r[1] + it_r.lo;
          s_nxt[2] = s_r[2] + it_r.hi;
          s_nxt[3] = s_r[3] - it_r.hi;
          odd_nxt = !odd_r;
          pc_nxt = pc_r + 5'd1;
        end
        OP_MIX_A, OP_MIX_B: begin
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r[0]) begin
            if (op == OP_MIX_A) begin
              case (step)
                2'd0, 2'd2: begin t_nxt[0] = prod[0]; t_nxt[1] = prod[1]; end
                2'd1: begin
                  t_nxt[0] = prod[0]; t_nxt[1] = prod[1];
                  s_nxt[0] = prod[0]; s_nxt[2] = prod[1];
                end
                default: begin s_nxt[1] = prod[0]; s_nxt[3] = prod[1]; end
              endcase
            end else begin
              case (step)
                2'd0, 2'd1: t_nxt[0] = prod[0];
                2'd2: begin s_nxt[2] = t_r[0]; t_nxt[0] = prod[0]; end
                default: s_nxt[1] = prod[0];
              endcase
            end
            if (step == 2'd3) begin
              pc_nxt = pc_r + 5'd1;
            end
          end
        end
        OP_ROT: begin
          s_nxt[0] = s_r[3];
          s_nxt[1] = s_r[0];
          s_nxt[2] = s_r[1];
          s_nxt[3] = s_r[2];
          pc_nxt = pc_r + 5'd1;
        end
        OP_TAIL: begin
          for (int w = 0; w < 4; w++) begin
            s_nxt[w] = tsum[w];
          end
          pc_nxt = pc_r + 5'd1;
        end
        OP_EMIT: begin
          if (!ofull) begin
            opush = 1'b1;
            if (ores.fin) begin
              busy_nxt = 1'b0;
              fresh_nxt = 1'b1;
            end else begin
              eidx_nxt = eidx_r + 2'd1;
              pc_nxt = pc_r + 5'd1;
            end
          end
        end
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fresh_r <= 1'b1;
      odd_r <= 1'b0;
      pc_r <= '0;
      cnt_r <= '0;
      eidx_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      fresh_r <= fresh_nxt;
      odd_r <= odd_nxt;
      pc_r <= pc_nxt;
      cnt_r <= cnt_nxt;
      eidx_r <= eidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < 4; w++) begin
      s_r[w] <= s_nxt[w];
    end
    for (int l = 0; l < 2; l++) begin
      t_r[l] <= t_nxt[l];
      ll_r[l] <= ll_nxt[l];
      cr_r[l] <= cr_nxt[l];
    end
    if (start) begin
      it_r <= head;
    end
  end

  // Result queue.
  assign ofull = (ocnt_r == 3'(OUT_DEPTH));
  assign out_empty = (ocnt_r == 3'd0);
  assign opop = out_pop && !out_empty;
  assign out_hash_word = oq_r[orp_r].hash;
  assign out_word_index = oq_r[orp_r].idx;
  assign out_final_word = oq_r[orp_r].fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r <= '0;
      orp_r <= '0;
      ocnt_r <= '0;
    end else begin
      owp_r <= owp_r + 2'(opush);
      orp_r <= orp_r + 2'(opop);
      ocnt_r <= ocnt_r + 3'(opush) - 3'(opop);
    end
  end

  always_ff @(posedge clk) begin
    if (opush) begin
      oq_r[owp_r] <= ores;
    end
  end
endmodule

@@ sv/mrsh_checker.sv @@
// Port-level checker of the stream hash and its bind to the top level.
`include "assert_macros.svh"

module mrsh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [63:0] out_hash_word,
  input logic [1:0]  out_word_index,
  input logic        out_final_word
);
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, out_empty)
  `ASSERT_NEXT(a_index_step, clk, rst_n, out_pop && !out_empty && !out_final_word, out_empty || (out_word_index == $past(out_word_index) + 2'd1))
  `ASSERT_NEXT(a_index_restart, clk, rst_n, out_pop && !out_empty && out_final_word, out_empty || (out_word_index == 2'd0))
  `ASSERT_NEXT(a_stall_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_hash_word))
endmodule

bind multiply_rotate_stream_hash mrsh_checker u_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_empty(out_empty),
  .out_pop(out_pop),
  .out_hash_word(out_hash_word),
  .out_word_index(out_word_index),
  .out_final_word(out_final_word)
);
